// ----- src/lpht_pkg.sv -----
// Package: payload types and constants for the linear-probe hash table.
package lpht_pkg;

    typedef enum logic [1:0] {
        KIND_PUT    = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_OCC   = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    localparam logic [15:0] HASH_MULT = 16'd37;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] key;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [31:0] value_out;
        logic [6:0]  entry_count;
        logic        table_empty;
    } t_rsp;

endpackage

// ----- src/lpht_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/linear_probe_hash_table.sv -----
// Top level: key-value table with open addressing, linear probing and tombstones.
module linear_probe_hash_table #(
    parameter int SLOTS      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [6:0]      i_cfg_wdata,
    input  logic            start,
    output logic            busy,
    input  lpht_pkg::t_req  i_req,
    output logic            o_valid,
    output lpht_pkg::t_rsp  o_rsp
);
// An operation is taken on start while busy is low and its result appears with
// o_valid for one cycle; the receiver cannot stall. The hash mod table_size is
// computed by a restoring divider. Each probe step is one RAM read followed by
// one compare. Clear sweeps all SLOTS entries, one a cycle; after reset the same
// sweep runs once before busy drops.

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW = $clog2(SLOTS + 1);
    localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DIV, S_READ, S_CHECK, S_WRITE, S_DONE
    } t_state;

    t_state             r_state;
    lpht_pkg::t_req     r_req;
    logic [SW-1:0]      r_size;
    logic [SW-1:0]      r_cnt;
    logic [SW-1:0]      r_steps;
    logic [15:0]        r_quo;
    logic [SW:0]        r_rem;
    logic [4:0]         r_bit;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_tomb;
    logic               r_have_tomb;
    logic [AW-1:0]      r_clr;
    logic               r_ok;
    logic [31:0]        r_vout;
    logic [6:0]         r_cfg;

    logic               st_we, k_we, v_we;
    logic [AW-1:0]      waddr;
    logic [1:0]         st_wd, st_rd;
    logic [15:0]        k_rd;
    logic [VW-1:0]      v_rd;

    // clear sweep started by an operation, as opposed to the one after reset
    logic busy_op;
    assign busy_op = r_ok;

    lpht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_status (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(waddr), .i_wdata(st_wd),
        .i_raddr(r_idx), .o_rdata(st_rd));
    lpht_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_key (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(waddr), .i_wdata(r_req.key),
        .i_raddr(r_idx), .o_rdata(k_rd));
    lpht_ram #(.WIDTH(VW), .DEPTH(SLOTS)) u_value (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(waddr), .i_wdata(r_req.value[VW-1:0]),
        .i_raddr(r_idx), .o_rdata(v_rd));

    // effective size clamped to 1..SLOTS
    logic [SW-1:0] eff_size;
    always_comb begin
        if (r_cfg == 7'd0) begin
            eff_size = SW'(1);
        end else if (32'(r_cfg) > SLOTS) begin
            eff_size = SW'(SLOTS);
        end else begin
            eff_size = SW'(r_cfg);
        end
    end

    logic [SW:0]   rem_try;
    logic [SW+1:0] rem_sh;
    logic          key_hit, at_end, insert_new;
    logic [AW-1:0] idx_next, ins_idx;
    always_comb begin
        rem_sh   = {r_rem, r_quo[15]};
        rem_try  = (rem_sh >= {2'b00, r_size}) ? (SW+1)'(rem_sh - {2'b00, r_size})
                                               : rem_sh[SW:0];
        idx_next = (32'(r_idx) + 1 >= 32'(r_size)) ? '0 : AW'(32'(r_idx) + 1);
        key_hit  = (st_rd == lpht_pkg::ST_OCC) && (k_rd == r_req.key);
        at_end   = (r_steps == SW'(1));
        ins_idx  = r_have_tomb ? r_tomb : r_idx;
        insert_new = (r_req.kind == lpht_pkg::KIND_PUT) && !key_hit;
    end

    always_comb begin
        st_we = 1'b0;
        k_we  = 1'b0;
        v_we  = 1'b0;
        waddr = r_idx;
        st_wd = lpht_pkg::ST_EMPTY;
        if (r_state == S_CLEAR) begin
            st_we = 1'b1;
            waddr = r_clr;
        end else if (r_state == S_WRITE) begin
            if (r_req.kind == lpht_pkg::KIND_REMOVE) begin
                st_we = 1'b1;
                st_wd = lpht_pkg::ST_TOMB;
            end else begin
                v_we  = 1'b1;
                if (insert_new) begin
                    waddr = ins_idx;
                    st_we = 1'b1;
                    k_we  = 1'b1;
                    st_wd = lpht_pkg::ST_OCC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_ok    <= 1'b0;
            r_cfg   <= 7'd64;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= AW'(32'(r_clr) + 1);
                    if (32'(r_clr) == SLOTS - 1) begin
                        r_clr   <= '0;
                        r_state <= busy_op ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_req  <= i_req;
                        r_size <= eff_size;
                        r_ok   <= 1'b0;
                        r_vout <= '0;
                        r_quo  <= 16'(i_req.key * lpht_pkg::HASH_MULT);
                        r_rem  <= '0;
                        r_bit  <= 5'd16;
                        r_have_tomb <= 1'b0;
                        r_steps <= eff_size;
                        if (i_req.kind == lpht_pkg::KIND_CLEAR) begin
                            r_cnt   <= '0;
                            r_ok    <= 1'b1;
                            r_state <= S_CLEAR;
                        end else if (i_req.kind == lpht_pkg::KIND_PUT
                                     && r_cnt >= eff_size) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= rem_try;
                    r_quo <= {r_quo[14:0], 1'b0};
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == 5'd1) begin
                        r_idx   <= AW'(rem_try);
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (st_rd == lpht_pkg::ST_EMPTY) begin
                        r_state <= (r_req.kind == lpht_pkg::KIND_PUT) ? S_WRITE : S_DONE;
                    end else if (key_hit) begin
                        r_state <= (r_req.kind == lpht_pkg::KIND_LOOKUP) ? S_DONE : S_WRITE;
                        if (r_req.kind == lpht_pkg::KIND_LOOKUP) begin
                            r_ok   <= 1'b1;
                            r_vout <= 32'(v_rd);
                        end
                    end else begin
                        if (st_rd == lpht_pkg::ST_TOMB && !r_have_tomb) begin
                            r_have_tomb <= 1'b1;
                            r_tomb      <= r_idx;
                        end
                        if (at_end) begin
                            // walk exhausted: put may still use a tombstone
                            if (r_req.kind == lpht_pkg::KIND_PUT &&
                                (r_have_tomb || st_rd == lpht_pkg::ST_TOMB)) begin
                                if (!r_have_tomb) begin
                                    r_tomb <= r_idx;
                                end
                                r_have_tomb <= 1'b1;
                                r_idx   <= r_idx;
                                r_state <= S_WRITE;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_steps <= r_steps - SW'(1);
                            r_idx   <= idx_next;
                            r_state <= S_READ;
                        end
                    end
                end
                S_WRITE: begin
                    // status/key RAM outputs still hold the last checked slot
                    r_ok <= 1'b1;
                    if (r_req.kind == lpht_pkg::KIND_REMOVE) begin
                        if (r_cnt != '0) begin
                            r_cnt <= r_cnt - SW'(1);
                        end
                    end else if (insert_new) begin
                        r_cnt <= r_cnt + SW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    always_comb begin
        o_rsp.ok          = r_ok;
        o_rsp.value_out   = r_vout;
        o_rsp.entry_count = 7'(r_cnt);
        o_rsp.table_empty = (r_cnt == '0);
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= SLOTS) else $error("entry count above slot count");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than a cycle");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted operation did not start");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid) else $error("done without result");
`endif
endmodule
